// File: design/pcpc_pkg.sv
// Package for the planar convex polygon check: field widths, status codes,
// sequencer states and sign-extension helpers.
// No dependencies; the channel interfaces and the check module refer to it by scoped names.
package pcpc_pkg;

   // Widths of the datapath (fixed by the 16-bit vertex coordinates)
   localparam int COORD_BITS  = 16;
   localparam int EDGE_BITS   = COORD_BITS + 1;
   localparam int CROSS_BITS  = 2 * EDGE_BITS + 1;
   localparam int OFFSET_BITS = CROSS_BITS + COORD_BITS + 2;
   localparam int PROD_BITS   = 2 * CROSS_BITS;
   localparam int ACC_BITS    = PROD_BITS + 2;
   localparam int TOL_BITS    = 40;
   localparam int VERTEX_BITS = 3 * COORD_BITS;

   // Last step of a cross product (6 products) and of a dot product (3 products),
   // each product taking a multiply step and an accumulate step
   localparam logic [3:0] CROSS_LAST_STEP = 4'd11;
   localparam logic [3:0] DOT_LAST_STEP   = 4'd5;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_COLLINEAR = 2'd1;
   localparam status_type STATUS_SHORT     = 2'd2;
   localparam status_type STATUS_OVERFLOW  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CROSS,
      ST_DOT,
      ST_DOTFIN,
      ST_DECIDE,
      ST_WL0,
      ST_WL1,
      ST_WL2,
      ST_WL3,
      ST_EDGE,
      ST_RESP
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EDGE_BITS-1:0]  edge_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   // Difference of two coordinates, one bit wider
   function automatic edge_type edge_diff(input coord_type a, input coord_type b);
      edge_type ea;
      edge_type eb;
      ea = EDGE_BITS'(a);
      eb = EDGE_BITS'(b);
      return ea - eb;
   endfunction

   function automatic cross_type ext_coord(input coord_type a);
      return CROSS_BITS'(a);
   endfunction

   function automatic cross_type ext_edge(input edge_type a);
      return CROSS_BITS'(a);
   endfunction

endpackage

// File: design/pcpc_channels.sv
// Handshake channels of the polygon check: vertex input, result output and
// tolerance register write. Depends on pcpc_pkg for the field widths.
interface pcpc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pcpc_pkg::COORD_BITS-1:0] vertex_x;
   logic signed [pcpc_pkg::COORD_BITS-1:0] vertex_y;
   logic signed [pcpc_pkg::COORD_BITS-1:0] vertex_z;
   logic                                  last_vertex;
   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pcpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       convex_polygon;
   logic       coplanar;
   logic       convex;
   logic [1:0] status;
   modport source (output valid, convex_polygon, coplanar, convex, status, input ready);
   modport sink (input valid, convex_polygon, coplanar, convex, status, output ready);
endinterface

interface pcpc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pcpc_pkg::TOL_BITS-1:0]     data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: design/pcpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcpc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/planar_convex_polygon_check.sv
// Planar convex polygon check. Vertices arrive one per transfer, the last one flagged;
// each, up to MAX_VERTICES, is stored in a vertex RAM. The third vertex sets the plane
// normal and offset, every later vertex is tested against the plane tolerance, and after
// the last vertex a walk over the RAM tests each turn against the turn at vertex 0, then
// one result is sent. All arithmetic runs on one shared 35x35 multiplier with a separate
// multiply and accumulate step per product. The walk reads the vertex RAM once per walk
// step and stops at the first failing turn. A new vertex is taken only in the idle state,
// once the work on the last one is done. Tolerance writes are taken in any cycle.
module planar_convex_polygon_check #(
   parameter int MAX_VERTICES = 64
) (
   input logic          clock,
   input logic          reset,
   pcpc_req_if.sink     req_port,
   pcpc_rsp_if.source   rsp_port,
   pcpc_csr_if.sink     csr_port
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   pcpc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                        count_ff;
   logic                                 ovf_ff, cop_ff, walk_ff, plane_ff, last_ff;
   logic [pcpc_pkg::TOL_BITS-1:0]        tol_ff;
   pcpc_pkg::coord_type                  v0_ff [3];
   pcpc_pkg::coord_type                  v1_ff [3];
   pcpc_pkg::coord_type                  pt_ff [3];
   pcpc_pkg::coord_type                  pv_ff [3];
   pcpc_pkg::coord_type                  cv_ff [3];
   pcpc_pkg::coord_type                  nv_ff [3];
   pcpc_pkg::edge_type                   ea_ff [3];
   pcpc_pkg::edge_type                   eb_ff [3];
   pcpc_pkg::cross_type                  cr_ff [3];
   pcpc_pkg::cross_type                  nrm_ff [3];
   pcpc_pkg::cross_type                  c0_ff [3];
   logic signed [pcpc_pkg::OFFSET_BITS-1:0] off_ff;
   logic signed [pcpc_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [pcpc_pkg::PROD_BITS-1:0] prod_ff;
   logic [3:0]                           k_ff;
   logic [AW-1:0]                        i_ff;
   pcpc_pkg::status_type                 status_ff;
   logic                                 cvx_ff;
   logic                                 rsp_valid_ff, rsp_cp_ff, rsp_cop_ff, rsp_cvx_ff;
   pcpc_pkg::status_type                 rsp_status_ff;

   pcpc_pkg::coord_type                  req_vtx [3];
   pcpc_pkg::coord_type                  rd_vtx [3];
   logic                                 req_fire, rsp_free, mem_we, mem_re;
   logic [AW-1:0]                        mem_raddr;
   logic [pcpc_pkg::VERTEX_BITS-1:0]     mem_rdata;
   pcpc_pkg::cross_type                  ma, mb;
   logic [2:0]                           jsel;
   logic signed [pcpc_pkg::ACC_BITS-1:0]  prod_ext, acc_neg;
   logic [pcpc_pkg::ACC_BITS-1:0]        acc_mag;
   logic                                 dot_pos, last_idx, nrm_zero;
   logic [CW:0]                          nidx;
   pcpc_pkg::status_type                 dec_status;

   assign req_vtx[0] = req_port.vertex_x;
   assign req_vtx[1] = req_port.vertex_y;
   assign req_vtx[2] = req_port.vertex_z;

   assign req_port.ready = (state_ff == pcpc_pkg::ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   // Vertex store
   assign mem_we = req_fire && (count_ff != CW'(MAX_VERTICES));

   pcpc_ram #(
      .WIDTH (pcpc_pkg::VERTEX_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_port.vertex_x, req_port.vertex_y, req_port.vertex_z}),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_vtx[0] = mem_rdata[3*pcpc_pkg::COORD_BITS-1:2*pcpc_pkg::COORD_BITS];
   assign rd_vtx[1] = mem_rdata[2*pcpc_pkg::COORD_BITS-1:pcpc_pkg::COORD_BITS];
   assign rd_vtx[2] = mem_rdata[pcpc_pkg::COORD_BITS-1:0];

   // Select multiplier operands for the current step
   assign jsel = k_ff[3:1];

   always_comb begin
      ma = '0;
      mb = '0;
      if (state_ff == pcpc_pkg::ST_CROSS) begin
         case (jsel)
            3'd0: begin
               ma = pcpc_pkg::ext_edge(ea_ff[1]); mb = pcpc_pkg::ext_edge(eb_ff[2]);
            end
            3'd1: begin
               ma = pcpc_pkg::ext_edge(eb_ff[1]); mb = pcpc_pkg::ext_edge(ea_ff[2]);
            end
            3'd2: begin
               ma = pcpc_pkg::ext_edge(eb_ff[0]); mb = pcpc_pkg::ext_edge(ea_ff[2]);
            end
            3'd3: begin
               ma = pcpc_pkg::ext_edge(ea_ff[0]); mb = pcpc_pkg::ext_edge(eb_ff[2]);
            end
            3'd4: begin
               ma = pcpc_pkg::ext_edge(ea_ff[0]); mb = pcpc_pkg::ext_edge(eb_ff[1]);
            end
            default: begin
               ma = pcpc_pkg::ext_edge(ea_ff[1]); mb = pcpc_pkg::ext_edge(eb_ff[0]);
            end
         endcase
      end else begin
         case (jsel)
            3'd0: begin
               ma = walk_ff ? cr_ff[0] : nrm_ff[0];
               mb = walk_ff ? c0_ff[0] : pcpc_pkg::ext_coord(pt_ff[0]);
            end
            3'd1: begin
               ma = walk_ff ? cr_ff[1] : nrm_ff[1];
               mb = walk_ff ? c0_ff[1] : pcpc_pkg::ext_coord(pt_ff[1]);
            end
            default: begin
               ma = walk_ff ? cr_ff[2] : nrm_ff[2];
               mb = walk_ff ? c0_ff[2] : pcpc_pkg::ext_coord(pt_ff[2]);
            end
         endcase
      end
   end

   // Accumulate: cross steps load then subtract, dot steps add
   assign prod_ext = pcpc_pkg::ACC_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == pcpc_pkg::ST_CROSS) begin
         acc_in = jsel[0] ? (acc_ff - prod_ext) : prod_ext;
      end else if (state_ff == pcpc_pkg::ST_DOT) begin
         acc_in = acc_ff + prod_ext;
      end
   end

   // Checks on a finished dot product
   assign acc_neg = -acc_ff;
   assign acc_mag = acc_ff[pcpc_pkg::ACC_BITS-1] ? acc_neg : acc_ff;
   assign dot_pos = !acc_ff[pcpc_pkg::ACC_BITS-1] && (acc_ff != '0);
   assign last_idx = (CW'(i_ff) == (count_ff - CW'(1)));
   assign nrm_zero = (nrm_ff[0] == '0) && (nrm_ff[1] == '0) && (nrm_ff[2] == '0);

   // Index of the vertex two ahead of the walk, wrapped around the polygon
   always_comb begin
      nidx = (CW + 1)'(i_ff) + (CW + 1)'(2);
      if (nidx >= (CW + 1)'(count_ff)) begin
         nidx = nidx - (CW + 1)'(count_ff);
      end
   end

   always_comb begin
      if (ovf_ff) begin
         dec_status = pcpc_pkg::STATUS_OVERFLOW;
      end else if (count_ff < CW'(3)) begin
         dec_status = pcpc_pkg::STATUS_SHORT;
      end else if (nrm_zero) begin
         dec_status = pcpc_pkg::STATUS_COLLINEAR;
      end else begin
         dec_status = pcpc_pkg::STATUS_OK;
      end
   end

   // Sequencer: next state and RAM reads
   always_comb begin
      state_in  = state_ff;
      mem_re    = 1'b0;
      mem_raddr = '0;
      unique case (state_ff)
         pcpc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (count_ff == CW'(MAX_VERTICES)) begin
                  state_in = req_port.last_vertex ? pcpc_pkg::ST_DECIDE : pcpc_pkg::ST_IDLE;
               end else if (count_ff == CW'(2)) begin
                  state_in = pcpc_pkg::ST_CROSS;
               end else if (count_ff > CW'(2)) begin
                  state_in = pcpc_pkg::ST_DOT;
               end else begin
                  state_in = req_port.last_vertex ? pcpc_pkg::ST_DECIDE : pcpc_pkg::ST_IDLE;
               end
            end
         end
         pcpc_pkg::ST_CROSS: begin
            if (k_ff == pcpc_pkg::CROSS_LAST_STEP) begin
               state_in = pcpc_pkg::ST_DOT;
            end
         end
         pcpc_pkg::ST_DOT: begin
            if (k_ff == pcpc_pkg::DOT_LAST_STEP) begin
               state_in = pcpc_pkg::ST_DOTFIN;
            end
         end
         pcpc_pkg::ST_DOTFIN: begin
            if (walk_ff) begin
               state_in = (!dot_pos || last_idx) ? pcpc_pkg::ST_RESP : pcpc_pkg::ST_EDGE;
            end else begin
               state_in = last_ff ? pcpc_pkg::ST_DECIDE : pcpc_pkg::ST_IDLE;
            end
         end
         pcpc_pkg::ST_DECIDE: begin
            state_in = (dec_status == pcpc_pkg::STATUS_OK) ? pcpc_pkg::ST_WL0 :
                       pcpc_pkg::ST_RESP;
         end
         pcpc_pkg::ST_WL0: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_ff - CW'(1));
            state_in  = pcpc_pkg::ST_WL1;
         end
         pcpc_pkg::ST_WL1: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = pcpc_pkg::ST_WL2;
         end
         pcpc_pkg::ST_WL2: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(1);
            state_in  = pcpc_pkg::ST_WL3;
         end
         pcpc_pkg::ST_WL3: begin
            state_in = pcpc_pkg::ST_EDGE;
         end
         pcpc_pkg::ST_EDGE: begin
            mem_re    = 1'b1;
            mem_raddr = nidx[AW-1:0];
            state_in  = pcpc_pkg::ST_CROSS;
         end
         pcpc_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = pcpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         cop_ff       <= 1'b1;
         walk_ff      <= 1'b0;
         plane_ff     <= 1'b0;
         tol_ff       <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            nrm_ff[c] <= '0;
         end
      end else begin
         // Take tolerance writes at any time
         if (csr_port.valid) begin
            tol_ff <= csr_port.data;
         end

         // Drop the result once transferred, load a new one when free
         if (state_ff == pcpc_pkg::ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Multiply every step; the odd step after it accumulates the product
         if (state_ff == pcpc_pkg::ST_CROSS || state_ff == pcpc_pkg::ST_DOT) begin
            prod_ff <= ma * mb;
         end

         unique case (state_ff)
            pcpc_pkg::ST_IDLE: begin
               if (req_fire) begin
                  last_ff <= req_port.last_vertex;
                  k_ff    <= '0;
                  if (count_ff == CW'(MAX_VERTICES)) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                     if (count_ff == CW'(0)) begin
                        v0_ff <= req_vtx;
                     end else if (count_ff == CW'(1)) begin
                        v1_ff <= req_vtx;
                     end else if (count_ff == CW'(2)) begin
                        for (int c = 0; c < 3; c++) begin
                           ea_ff[c] <= pcpc_pkg::edge_diff(v1_ff[c], v0_ff[c]);
                           eb_ff[c] <= pcpc_pkg::edge_diff(req_vtx[c], v0_ff[c]);
                        end
                        pt_ff    <= v0_ff;
                        plane_ff <= 1'b1;
                     end else begin
                        pt_ff    <= req_vtx;
                        plane_ff <= 1'b0;
                        acc_ff   <= pcpc_pkg::ACC_BITS'(off_ff);
                     end
                  end
               end
            end
            pcpc_pkg::ST_CROSS: begin
               // Store each finished component
               if (k_ff[0] && jsel[0]) begin
                  cr_ff[k_ff[3:2]] <= acc_in[pcpc_pkg::CROSS_BITS-1:0];
               end
               if (k_ff == pcpc_pkg::CROSS_LAST_STEP) begin
                  k_ff   <= '0;
                  acc_ff <= '0;
                  if (!walk_ff) begin
                     nrm_ff[0] <= cr_ff[0];
                     nrm_ff[1] <= cr_ff[1];
                     nrm_ff[2] <= acc_in[pcpc_pkg::CROSS_BITS-1:0];
                  end else if (i_ff == '0) begin
                     c0_ff[0] <= cr_ff[0];
                     c0_ff[1] <= cr_ff[1];
                     c0_ff[2] <= acc_in[pcpc_pkg::CROSS_BITS-1:0];
                  end
               end else begin
                  k_ff <= k_ff + 4'd1;
                  if (k_ff[0]) begin
                     acc_ff <= acc_in;
                  end
               end
            end
            pcpc_pkg::ST_DOT: begin
               k_ff <= k_ff + 4'd1;
               if (k_ff[0]) begin
                  acc_ff <= acc_in;
               end
            end
            pcpc_pkg::ST_DOTFIN: begin
               if (walk_ff) begin
                  // Advance the window or stop at the first failing turn
                  cvx_ff <= dot_pos;
                  if (dot_pos && !last_idx) begin
                     pv_ff <= cv_ff;
                     cv_ff <= nv_ff;
                     nv_ff <= rd_vtx;
                     i_ff  <= i_ff + AW'(1);
                  end
               end else if (plane_ff) begin
                  off_ff <= acc_neg[pcpc_pkg::OFFSET_BITS-1:0];
               end else if (acc_mag > pcpc_pkg::ACC_BITS'(tol_ff)) begin
                  cop_ff <= 1'b0;
               end
            end
            pcpc_pkg::ST_DECIDE: begin
               status_ff <= dec_status;
               cvx_ff    <= 1'b0;
               i_ff      <= '0;
               walk_ff   <= (dec_status == pcpc_pkg::STATUS_OK);
            end
            pcpc_pkg::ST_WL0: begin
            end
            pcpc_pkg::ST_WL1: begin
               pv_ff <= rd_vtx;
            end
            pcpc_pkg::ST_WL2: begin
               cv_ff <= rd_vtx;
            end
            pcpc_pkg::ST_WL3: begin
               nv_ff <= rd_vtx;
            end
            pcpc_pkg::ST_EDGE: begin
               k_ff <= '0;
               for (int c = 0; c < 3; c++) begin
                  ea_ff[c] <= pcpc_pkg::edge_diff(pv_ff[c], cv_ff[c]);
                  eb_ff[c] <= pcpc_pkg::edge_diff(nv_ff[c], cv_ff[c]);
               end
            end
            pcpc_pkg::ST_RESP: begin
               if (rsp_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_cop_ff    <= (status_ff == pcpc_pkg::STATUS_OK) && cop_ff;
                  rsp_cvx_ff    <= (status_ff == pcpc_pkg::STATUS_OK) && cvx_ff;
                  rsp_cp_ff     <= (status_ff == pcpc_pkg::STATUS_OK) && cop_ff && cvx_ff;
                  // Clear the polygon
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
                  cop_ff   <= 1'b1;
                  walk_ff  <= 1'b0;
                  off_ff   <= '0;
                  for (int c = 0; c < 3; c++) begin
                     nrm_ff[c] <= '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.convex_polygon = rsp_cp_ff;
   assign rsp_port.coplanar       = rsp_cop_ff;
   assign rsp_port.convex         = rsp_cvx_ff;
   assign rsp_port.status         = rsp_status_ff;

   // A convex result needs a clean status and both partial checks
   a_cp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.convex_polygon |->
         (rsp_port.status == pcpc_pkg::STATUS_OK) && rsp_port.coplanar && rsp_port.convex)
      else $error("convex_polygon set without its conditions");

   // A failure status clears the check flags
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.status != pcpc_pkg::STATUS_OK) |->
         !rsp_port.coplanar && !rsp_port.convex)
      else $error("check flags set with failure status");

   // The fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   // The walk index stays inside the polygon
   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      walk_ff && (state_ff != pcpc_pkg::ST_RESP) |-> (CW'(i_ff) < count_ff))
      else $error("walk index outside polygon");

endmodule

// File: dv/tb.sv
// Self-checking testbench for planar_convex_polygon_check: vertex streams under
// random idling and stalls, checked against an exact integer convexity predictor.
// Depends on pcpc_pkg and the channel interfaces in pcpc_channels.sv.
`timescale 1ns / 100ps

module tb;

   localparam int MAX_VERTS   = 64;
   localparam int IDLE_LIMIT  = 40000;
   localparam int DRAIN_TICKS = 60;
   localparam int ITEM_GOAL   = 700;
   localparam logic [pcpc_pkg::TOL_BITS-1:0] TOL_MAX = {pcpc_pkg::TOL_BITS{1'b1}};

   typedef struct {
      longint x;
      longint y;
      longint z;
   } vec_type;

   typedef struct {
      bit                   convex_polygon;
      bit                   coplanar;
      bit                   convex;
      pcpc_pkg::status_type status;
   } verdict_type;

   // Exact polygon convexity predictor and queue of pending verdicts
   class polygon_scoreboard;
      vec_type                       vertices [MAX_VERTS];
      int                            count;
      vec_type                       normal;
      longint                        offset;
      bit                            on_plane;
      bit                            overflowed;
      logic [pcpc_pkg::TOL_BITS-1:0] tolerance;
      verdict_type                   pending_verdicts [$];
      int                            errors;

      function void clear_polygon();
         count      = 0;
         normal     = '{0, 0, 0};
         offset     = 0;
         on_plane   = 1;
         overflowed = 0;
      endfunction

      function vec_type diff(vec_type a, vec_type b);
         return '{a.x - b.x, a.y - b.y, a.z - b.z};
      endfunction

      function vec_type cross_prod(vec_type a, vec_type b);
         return '{a.y * b.z - b.y * a.z, b.x * a.z - a.x * b.z, a.x * b.y - a.y * b.x};
      endfunction

      function vec_type turn(int i, int n);
         int prev;
         int next;
         prev = (i == 0) ? n - 1 : i - 1;
         next = (i + 1 == n) ? 0 : i + 1;
         return cross_prod(diff(vertices[prev], vertices[i]),
                           diff(vertices[next], vertices[i]));
      endfunction

      // Dot product at 128 bits, since turn products reach 35 bits each
      function bit dot_positive(vec_type a, vec_type b);
         logic signed [127:0] ax, ay, az, bx, by, bz, acc;
         ax = a.x; ay = a.y; az = a.z;
         bx = b.x; by = b.y; bz = b.z;
         acc = ax * bx + ay * by + az * bz;
         return acc > 0;
      endfunction

      function void note_vertex(pcpc_pkg::coord_type x, pcpc_pkg::coord_type y,
                                pcpc_pkg::coord_type z, bit last);
         vec_type     p;
         longint      residue;
         longint      mag;
         verdict_type v;
         vec_type     c0;
         p = '{longint'(x), longint'(y), longint'(z)};
         if (count >= MAX_VERTS) begin
            overflowed = 1;
         end else begin
            vertices[count] = p;
            if (count == 2) begin
               normal = cross_prod(diff(vertices[1], vertices[0]),
                                   diff(vertices[2], vertices[0]));
               offset = -(normal.x * vertices[0].x + normal.y * vertices[0].y
                          + normal.z * vertices[0].z);
            end else if (count > 2) begin
               residue = normal.x * p.x + normal.y * p.y + normal.z * p.z + offset;
               mag = residue < 0 ? -residue : residue;
               if (mag > longint'({24'd0, tolerance}))
                  on_plane = 0;
            end
            count++;
         end
         if (!last)
            return;
         v = '{0, 0, 0, pcpc_pkg::STATUS_OK};
         if (overflowed)
            v.status = pcpc_pkg::STATUS_OVERFLOW;
         else if (count < 3)
            v.status = pcpc_pkg::STATUS_SHORT;
         else if (normal.x == 0 && normal.y == 0 && normal.z == 0)
            v.status = pcpc_pkg::STATUS_COLLINEAR;
         if (v.status == pcpc_pkg::STATUS_OK) begin
            c0 = turn(0, count);
            v.coplanar = on_plane;
            v.convex = 1;
            for (int i = 0; i < count && v.convex; i++)
               v.convex = dot_positive(turn(i, count), c0);
            v.convex_polygon = v.coplanar && v.convex;
         end
         pending_verdicts.push_back(v);
         clear_polygon();
      endfunction

      function void check_result(bit cp, bit cop, bit cvx, pcpc_pkg::status_type st);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $error("result with no pending verdict");
            errors++;
            return;
         end
         v = pending_verdicts.pop_front();
         if (cp !== v.convex_polygon) begin
            $error("convex_polygon: expected %0d actual %0d", v.convex_polygon, cp);
            errors++;
         end
         if (cop !== v.coplanar) begin
            $error("coplanar: expected %0d actual %0d", v.coplanar, cop);
            errors++;
         end
         if (cvx !== v.convex) begin
            $error("convex: expected %0d actual %0d", v.convex, cvx);
            errors++;
         end
         if (st !== v.status) begin
            $error("status: expected %0d actual %0d", v.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   pcpc_req_if req_if ();
   pcpc_rsp_if rsp_if ();
   pcpc_csr_if csr_if ();

   planar_convex_polygon_check #(.MAX_VERTICES(MAX_VERTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source),
      .csr_port (csr_if.sink)
   );

   polygon_scoreboard sb;
   int      send_idle_pct;
   int      stall_pct;
   int      vertices_sent;
   int      quiet_cycles;
   vec_type outline [$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Randomize result backpressure
   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   // Track transfers on the vertex and result channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_vertex(req_if.vertex_x, req_if.vertex_y, req_if.vertex_z,
                           req_if.last_vertex);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.convex_polygon, rsp_if.coplanar, rsp_if.convex,
                            rsp_if.status);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Send one vertex; valid stays high into the next call unless that call idles
   task automatic send_vertex(vec_type p, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.vertex_x    <= pcpc_pkg::coord_type'(p.x);
      req_if.vertex_y    <= pcpc_pkg::coord_type'(p.y);
      req_if.vertex_z    <= pcpc_pkg::coord_type'(p.z);
      req_if.last_vertex <= last;
      do @(posedge clock); while (!req_if.ready);
      vertices_sent++;
   endtask

   task automatic send_outline();
      foreach (outline[i])
         send_vertex(outline[i], i == outline.size() - 1);
      outline.delete();
   endtask

   // Drop valid and hold until every verdict has come, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [pcpc_pkg::TOL_BITS-1:0] value);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.tolerance = value;
   endtask

   function automatic void add(longint x, longint y, longint z);
      outline.push_back('{x, y, z});
   endfunction

   // Build a polygon on a circle, placed in an axis or tilted plane; it may be dented or nudged below
   function automatic void build_ring(int n);
      real     base;
      real     ang;
      int      radius;
      int      cu, cv, cw;
      int      plane;
      int      u, v;
      bit      reverse;
      vec_type tmp;
      plane   = $urandom_range(3);
      radius  = (plane == 3) ? $urandom_range(20000, 50) : $urandom_range(30000, 50);
      cu      = $urandom_range(2000) - 1000;
      cv      = $urandom_range(2000) - 1000;
      cw      = $urandom_range(20000) - 10000;
      base    = $urandom_range(6283) / 1000.0;
      reverse = $urandom_range(1);
      for (int i = 0; i < n; i++) begin
         ang = base + 6.2831853 * i / n + ($urandom_range(600) / 1000.0 - 0.3) * 3.14 / n;
         if (reverse)
            ang = -ang;
         u = cu + $rtoi(radius * $cos(ang));
         v = cv + $rtoi(radius * $sin(ang));
         case (plane)
            0: add(u, v, cw);
            1: add(cw, u, v);
            2: add(v, cw, u);
            default: add(u, v, (u + v) / 2 + cw / 4);
         endcase
      end
      // Occasionally dent the outline or nudge a vertex off the plane
      if (n >= 4 && $urandom_range(99) < 20) begin
         tmp = outline[1];
         outline[1] = outline[2];
         outline[2] = tmp;
      end
      if (n >= 4 && $urandom_range(99) < 15)
         outline[n - 1].z = outline[n - 1].z + ($urandom_range(1) ? 1 : -1);
   endfunction

   function automatic longint rand_coord();
      return longint'(pcpc_pkg::coord_type'($urandom()));
   endfunction

   task automatic random_polygon();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 3)
         n = $urandom_range(MAX_VERTS + 4, MAX_VERTS - 1);
      else if (pick < 8)
         n = $urandom_range(2, 1);
      else
         n = $urandom_range(10, 3);
      if (pick >= 8 && pick < 20) begin
         for (int i = 0; i < n; i++)
            add(rand_coord(), rand_coord(), rand_coord());
      end else begin
         build_ring(n < 3 ? 3 : n);
         while (outline.size() > n)
            void'(outline.pop_back());
      end
      send_outline();
   endtask

   task automatic directed_polygons();
      // Square in the plane z = 0
      add(0, 0, 0); add(100, 0, 0); add(100, 100, 0); add(0, 100, 0);
      send_outline();
      // Extreme coordinates on a triangle
      add(-32768, -32768, -32768); add(32767, -32768, 32767); add(32767, 32767, -32768);
      send_outline();
      // Concave quad
      add(0, 0, 5); add(100, 0, 5); add(20, 20, 5); add(0, 100, 5);
      send_outline();
      // First three collinear
      add(0, 0, 0); add(1, 1, 1); add(2, 2, 2); add(0, 5, 0);
      send_outline();
      // Too few vertices
      add(7, 7, 7);
      send_outline();
      add(1, 2, 3); add(-4, 5, -6);
      send_outline();
      // Off the plane by one unit
      add(0, 0, 0); add(10, 0, 0); add(10, 10, 1); add(0, 10, 0);
      send_outline();
      // Degenerate turn at the first vertex: last vertex repeats it
      add(0, 0, 0); add(50, 0, 0); add(50, 50, 0); add(0, 0, 0);
      send_outline();
      // Too many vertices
      build_ring(MAX_VERTS + 2);
      send_outline();
   endtask

   initial begin
      sb = new();
      sb.clear_polygon();
      sb.tolerance       = '0;
      sb.errors          = 0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      vertices_sent      = 0;
      quiet_cycles       = 0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.vertex_x    = '0;
      req_if.vertex_y    = '0;
      req_if.vertex_z    = '0;
      req_if.last_vertex = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.data        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_tolerance('0);
      directed_polygons();
      write_tolerance(TOL_MAX);
      directed_polygons();

      // Four random phases, each with its own tolerance and its own idling and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_tolerance('0);
            1: write_tolerance(pcpc_pkg::TOL_BITS'($urandom_range(200000)));
            2: write_tolerance(pcpc_pkg::TOL_BITS'({$urandom(), $urandom()}));
            default: write_tolerance(TOL_MAX);
         endcase
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 50 : 35) : 0;
         stall_pct     = (phase == 2 || phase == 3) ? (phase == 2 ? 50 : 35) : 0;
         while (vertices_sent < ITEM_GOAL * (phase + 1) / 4 + 40) begin
            random_polygon();
            if ($urandom_range(99) < 5)
               drain();
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
